### hdl/wstd_pkg.sv
// Package with the shared constants, types and codes of the weighted server task dispatcher.
package wstd_pkg;

	localparam int NUM_SERVERS     = 16;
	localparam int MAX_BATCH_TASKS = 1048576;

	localparam int IDX_W    = 4;
	localparam int WEIGHT_W = 20;
	localparam int DUR_W    = 20;
	localparam int TIME_W   = 40;
	localparam int COUNT_W  = $clog2(MAX_BATCH_TASKS + 1);
	localparam int SRV_W    = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

	localparam int GROUP      = 4;
	localparam int NUM_GROUPS = (NUM_SERVERS + GROUP - 1) / GROUP;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TASK = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_SERVER = 2'd1,
		STATUS_LIMIT     = 2'd2
	} result_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RED1,
		ST_RED2,
		ST_SEL1,
		ST_SEL2
	} state_t;

	typedef struct packed {
		logic           capture;
		logic           load_write;
		logic           prep;
		logic           red1;
		logic           red2;
		logic           sel1;
		logic           commit;
		logic           emit_err;
		result_status_t err_code;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic idx_ok;
		logic any_present;
		logic limit;
	} stat_t;

endpackage

### hdl/wstd_ctrl.sv
// Controller state machine that sequences decode, the two reductions and the commit.
module wstd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  wstd_pkg::stat_t      stat,
	output wstd_pkg::cmd_t       cmd,
	output logic                 busy
);

	wstd_pkg::state_t state_q;
	wstd_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wstd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			wstd_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = wstd_pkg::ST_DECODE;
				end
			end
			wstd_pkg::ST_DECODE: begin
				if (stat.is_load || !stat.any_present || stat.limit) begin
					state_nxt = wstd_pkg::ST_IDLE;
				end else begin
					state_nxt = wstd_pkg::ST_RED1;
				end
			end
			wstd_pkg::ST_RED1: state_nxt = wstd_pkg::ST_RED2;
			wstd_pkg::ST_RED2: state_nxt = wstd_pkg::ST_SEL1;
			wstd_pkg::ST_SEL1: state_nxt = wstd_pkg::ST_SEL2;
			wstd_pkg::ST_SEL2: state_nxt = wstd_pkg::ST_IDLE;
			default: state_nxt = wstd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.err_code = wstd_pkg::STATUS_OK;
		busy = (state_q != wstd_pkg::ST_IDLE);
		unique case (state_q)
			wstd_pkg::ST_IDLE: begin
				cmd.capture = start;
			end
			wstd_pkg::ST_DECODE: begin
				if (stat.is_load) begin
					cmd.load_write = stat.idx_ok;
				end else if (!stat.any_present) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = wstd_pkg::STATUS_NO_SERVER;
				end else if (stat.limit) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = wstd_pkg::STATUS_LIMIT;
				end else begin
					cmd.prep = 1'b1;
				end
			end
			wstd_pkg::ST_RED1: cmd.red1 = 1'b1;
			wstd_pkg::ST_RED2: cmd.red2 = 1'b1;
			wstd_pkg::ST_SEL1: cmd.sel1 = 1'b1;
			wstd_pkg::ST_SEL2: cmd.commit = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

### hdl/wstd_dp.sv
// Datapath with the server table, batch time and count, the grouped reductions and the result.
module wstd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wstd_pkg::cmd_t                  cmd,
	output wstd_pkg::stat_t                 stat,
	input  logic                            operation,
	input  logic [wstd_pkg::IDX_W-1:0]      server_index,
	input  logic [wstd_pkg::WEIGHT_W-1:0]   server_weight,
	input  logic [wstd_pkg::DUR_W-1:0]      task_duration,
	output logic                            done,
	output logic [wstd_pkg::IDX_W-1:0]      assigned_server,
	output logic [wstd_pkg::TIME_W-1:0]     start_time,
	output logic [1:0]                      status
);

	logic                              op_q;
	logic [wstd_pkg::IDX_W-1:0]        idx_q;
	logic [wstd_pkg::WEIGHT_W-1:0]     win_q;
	logic [wstd_pkg::DUR_W-1:0]        dur_q;

	logic [wstd_pkg::WEIGHT_W-1:0]     weight_q [wstd_pkg::NUM_SERVERS];
	logic [wstd_pkg::NUM_SERVERS-1:0]  present_q;
	logic [wstd_pkg::TIME_W-1:0]       rel_q [wstd_pkg::NUM_SERVERS];
	logic [wstd_pkg::TIME_W-1:0]       time_q;
	logic [wstd_pkg::COUNT_W-1:0]      count_q;

	logic [wstd_pkg::TIME_W-1:0]       t0_s1;
	logic [wstd_pkg::TIME_W-1:0]       gmin_s2 [wstd_pkg::NUM_GROUPS];
	logic [wstd_pkg::NUM_GROUPS-1:0]   gfree_s2;
	logic [wstd_pkg::TIME_W-1:0]       t_s3;
	logic [wstd_pkg::SRV_W-1:0]        gidx_s4 [wstd_pkg::NUM_GROUPS];
	logic [wstd_pkg::WEIGHT_W-1:0]     gw_s4 [wstd_pkg::NUM_GROUPS];
	logic [wstd_pkg::NUM_GROUPS-1:0]   gfound_s4;

	logic                              done_q;
	logic [wstd_pkg::IDX_W-1:0]        server_q;
	logic [wstd_pkg::TIME_W-1:0]       start_q;
	logic [1:0]                        status_q;

	logic [wstd_pkg::TIME_W-1:0]       count_ext;
	logic [wstd_pkg::TIME_W-1:0]       t0_nxt;
	logic [wstd_pkg::TIME_W-1:0]       gmin_nxt [wstd_pkg::NUM_GROUPS];
	logic [wstd_pkg::NUM_GROUPS-1:0]   gfree_nxt;
	logic [wstd_pkg::TIME_W-1:0]       t_nxt;
	logic [wstd_pkg::SRV_W-1:0]        gidx_nxt [wstd_pkg::NUM_GROUPS];
	logic [wstd_pkg::WEIGHT_W-1:0]     gw_nxt [wstd_pkg::NUM_GROUPS];
	logic [wstd_pkg::NUM_GROUPS-1:0]   gfound_nxt;
	logic [wstd_pkg::SRV_W-1:0]        best_idx;
	logic [wstd_pkg::TIME_W:0]         rel_sum;
	logic [wstd_pkg::TIME_W-1:0]       rel_new;

	assign stat.is_load     = (op_q == wstd_pkg::OP_LOAD);
	assign stat.idx_ok      = (32'(idx_q) < wstd_pkg::NUM_SERVERS);
	assign stat.any_present = |present_q;
	assign stat.limit       = (32'(count_q) >= wstd_pkg::MAX_BATCH_TASKS);

	assign count_ext = wstd_pkg::TIME_W'(count_q);
	assign t0_nxt    = (count_ext > time_q) ? count_ext : time_q;

	always_comb begin
		int n;
		for (int g = 0; g < wstd_pkg::NUM_GROUPS; g++) begin
			gmin_nxt[g]  = wstd_pkg::TIME_MAX;
			gfree_nxt[g] = 1'b0;
			for (int k = 0; k < wstd_pkg::GROUP; k++) begin
				n = g * wstd_pkg::GROUP + k;
				if (n < wstd_pkg::NUM_SERVERS) begin
					if (present_q[n]) begin
						if (rel_q[n] <= t0_s1) begin
							gfree_nxt[g] = 1'b1;
						end
						if (rel_q[n] < gmin_nxt[g]) begin
							gmin_nxt[g] = rel_q[n];
						end
					end
				end
			end
		end
	end

	always_comb begin
		logic [wstd_pkg::TIME_W-1:0] m;
		m = wstd_pkg::TIME_MAX;
		for (int g = 0; g < wstd_pkg::NUM_GROUPS; g++) begin
			if (gmin_s2[g] < m) begin
				m = gmin_s2[g];
			end
		end
		t_nxt = (|gfree_s2) ? t0_s1 : m;
	end

	always_comb begin
		int n;
		for (int g = 0; g < wstd_pkg::NUM_GROUPS; g++) begin
			gidx_nxt[g]   = '0;
			gw_nxt[g]     = '0;
			gfound_nxt[g] = 1'b0;
			for (int k = 0; k < wstd_pkg::GROUP; k++) begin
				n = g * wstd_pkg::GROUP + k;
				if (n < wstd_pkg::NUM_SERVERS) begin
					if (present_q[n] && (rel_q[n] <= t_s3)) begin
						if (!gfound_nxt[g] || (weight_q[n] < gw_nxt[g])) begin
							gidx_nxt[g]   = wstd_pkg::SRV_W'(n);
							gw_nxt[g]     = weight_q[n];
							gfound_nxt[g] = 1'b1;
						end
					end
				end
			end
		end
	end

	always_comb begin
		logic                          found;
		logic [wstd_pkg::WEIGHT_W-1:0] bw;
		found    = 1'b0;
		bw       = '0;
		best_idx = '0;
		for (int g = 0; g < wstd_pkg::NUM_GROUPS; g++) begin
			if (gfound_s4[g] && (!found || (gw_s4[g] < bw))) begin
				found    = 1'b1;
				bw       = gw_s4[g];
				best_idx = gidx_s4[g];
			end
		end
	end

	assign rel_sum = {1'b0, t_s3} + (wstd_pkg::TIME_W + 1)'(dur_q);
	assign rel_new = rel_sum[wstd_pkg::TIME_W] ? wstd_pkg::TIME_MAX
	                                          : rel_sum[wstd_pkg::TIME_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			idx_q <= server_index;
			win_q <= server_weight;
			dur_q <= task_duration;
		end
		if (cmd.prep) begin
			t0_s1 <= t0_nxt;
		end
		if (cmd.red1) begin
			gmin_s2  <= gmin_nxt;
			gfree_s2 <= gfree_nxt;
		end
		if (cmd.red2) begin
			t_s3 <= t_nxt;
		end
		if (cmd.sel1) begin
			gidx_s4   <= gidx_nxt;
			gw_s4     <= gw_nxt;
			gfound_s4 <= gfound_nxt;
		end
		if (cmd.commit) begin
			server_q <= wstd_pkg::IDX_W'(best_idx);
			start_q  <= t_s3;
			status_q <= wstd_pkg::STATUS_OK;
		end else if (cmd.emit_err) begin
			server_q <= '0;
			start_q  <= '0;
			status_q <= cmd.err_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wstd_pkg::NUM_SERVERS; i++) begin
				weight_q[i] <= '0;
				rel_q[i]    <= '0;
			end
			present_q <= '0;
			time_q    <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.commit | cmd.emit_err;
			if (cmd.load_write) begin
				weight_q[idx_q[wstd_pkg::SRV_W-1:0]]  <= win_q;
				present_q[idx_q[wstd_pkg::SRV_W-1:0]] <= 1'b1;
				for (int i = 0; i < wstd_pkg::NUM_SERVERS; i++) begin
					rel_q[i] <= '0;
				end
				time_q  <= '0;
				count_q <= '0;
			end else if (cmd.commit) begin
				rel_q[best_idx] <= rel_new;
				time_q          <= t_s3;
				count_q         <= count_q + 1'b1;
			end
		end
	end

	assign done            = done_q;
	assign assigned_server = server_q;
	assign start_time      = start_q;
	assign status          = status_q;

endmodule

### hdl/weighted_server_task_dispatcher.sv
// Top level of the weighted server task dispatcher: controller, datapath and checks.
//
// A word is taken when start is high and busy is low. A load word keeps busy high for one
// cycle, in which the decode state writes it, and it gives no result. A task word keeps
// busy high through ST_DECODE, then ST_RED1 and ST_RED2 for the grouped minimum over
// release times and ST_SEL1 and ST_SEL2 for the grouped weight search over free servers,
// the second of which commits. The commit registers its result onto assigned_server,
// start_time and status, shown while done is high. The result cannot be held off, and a
// new word may be started in that same cycle. A task that finds no server loaded, or a
// batch at its bound, keeps busy high for one cycle and returns its result, registered
// from the decode state, with status set.
module weighted_server_task_dispatcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            operation,
	input  logic [wstd_pkg::IDX_W-1:0]      server_index,
	input  logic [wstd_pkg::WEIGHT_W-1:0]   server_weight,
	input  logic [wstd_pkg::DUR_W-1:0]      task_duration,
	output logic                            done,
	output logic [wstd_pkg::IDX_W-1:0]      assigned_server,
	output logic [wstd_pkg::TIME_W-1:0]     start_time,
	output logic [1:0]                      status
);

	wstd_pkg::cmd_t  cmd;
	wstd_pkg::stat_t stat;

	wstd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	wstd_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.operation       (operation),
		.server_index    (server_index),
		.server_weight   (server_weight),
		.task_duration   (task_duration),
		.done            (done),
		.assigned_server (assigned_server),
		.start_time      (start_time),
		.status          (status)
	);

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a word is in progress");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a word in progress");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != wstd_pkg::STATUS_OK)) |-> (assigned_server == '0 && start_time == '0))
		else $error("error result carries a server or a start time");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");
`endif

endmodule

### tb/weighted_server_task_dispatcher_test.sv
// Testbench for the weighted server task dispatcher, with its scoreboard and stimulus.
`timescale 1ns / 100ps

module weighted_server_task_dispatcher_test;

	localparam int ITEM_TARGET = 1200;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [wstd_pkg::DUR_W-1:0] DUR_MAX = {wstd_pkg::DUR_W{1'b1}};
	localparam logic [wstd_pkg::WEIGHT_W-1:0] WEIGHT_MAX = {wstd_pkg::WEIGHT_W{1'b1}};

	typedef struct {
		logic [wstd_pkg::IDX_W-1:0]  srv;
		logic [wstd_pkg::TIME_W-1:0] start_sec;
		wstd_pkg::result_status_t    code;
	} grant_t;

	class dispatch_board;
		logic [wstd_pkg::WEIGHT_W-1:0] weight_of [wstd_pkg::NUM_SERVERS];
		logic [wstd_pkg::TIME_W-1:0]   busy_until [wstd_pkg::NUM_SERVERS];
		logic [wstd_pkg::NUM_SERVERS-1:0] loaded;
		logic [wstd_pkg::TIME_W-1:0]   clock_sec;
		logic [wstd_pkg::COUNT_W-1:0]  batch_tasks;
		grant_t expected_grants [$];
		int mismatches;
		int orphans;
		int grants_ok;
		int grants_empty;
		int loads_seen;
		logic [wstd_pkg::TIME_W-1:0] latest_start;

		function new();
			loaded = '0;
			clock_sec = '0;
			batch_tasks = '0;
			latest_start = '0;
			mismatches = 0;
			orphans = 0;
			grants_ok = 0;
			grants_empty = 0;
			loads_seen = 0;
			for (int i = 0; i < wstd_pkg::NUM_SERVERS; i++) begin
				weight_of[i] = '0;
				busy_until[i] = '0;
			end
		endfunction

		// Work out the grant for one accepted word and update the server table.
		function void note_word(logic op, logic [wstd_pkg::IDX_W-1:0] idx,
				logic [wstd_pkg::WEIGHT_W-1:0] wgt, logic [wstd_pkg::DUR_W-1:0] dur);
			grant_t g;
			logic [wstd_pkg::TIME_W-1:0] t;
			logic [wstd_pkg::TIME_W-1:0] earliest;
			logic [wstd_pkg::TIME_W:0] finish_sec;
			logic any_free;
			logic found;
			int best;
			if (op == wstd_pkg::OP_LOAD) begin
				loads_seen++;
				if (idx < wstd_pkg::NUM_SERVERS) begin
					weight_of[idx] = wgt;
					loaded[idx] = 1'b1;
					for (int i = 0; i < wstd_pkg::NUM_SERVERS; i++)
						busy_until[i] = '0;
					clock_sec = '0;
					batch_tasks = '0;
				end
				return;
			end
			g.srv = '0;
			g.start_sec = '0;
			g.code = wstd_pkg::STATUS_OK;
			if (loaded == '0) begin
				g.code = wstd_pkg::STATUS_NO_SERVER;
			end else if (batch_tasks >= wstd_pkg::MAX_BATCH_TASKS) begin
				g.code = wstd_pkg::STATUS_LIMIT;
			end else begin
				t = clock_sec;
				if (wstd_pkg::TIME_W'(batch_tasks) > t)
					t = wstd_pkg::TIME_W'(batch_tasks);
				any_free = 1'b0;
				earliest = wstd_pkg::TIME_MAX;
				for (int i = 0; i < wstd_pkg::NUM_SERVERS; i++) begin
					if (loaded[i]) begin
						if (busy_until[i] <= t)
							any_free = 1'b1;
						if (busy_until[i] < earliest)
							earliest = busy_until[i];
					end
				end
				if (!any_free)
					t = earliest;
				found = 1'b0;
				best = 0;
				for (int i = 0; i < wstd_pkg::NUM_SERVERS; i++) begin
					if (loaded[i] && busy_until[i] <= t &&
							(!found || weight_of[i] < weight_of[best])) begin
						best = i;
						found = 1'b1;
					end
				end
				clock_sec = t;
				finish_sec = {1'b0, t} + (wstd_pkg::TIME_W + 1)'(dur);
				busy_until[best] = (finish_sec > {1'b0, wstd_pkg::TIME_MAX}) ?
					wstd_pkg::TIME_MAX : finish_sec[wstd_pkg::TIME_W-1:0];
				batch_tasks++;
				g.srv = wstd_pkg::IDX_W'(best);
				g.start_sec = t;
			end
			expected_grants.push_back(g);
		endfunction

		function void check_word(logic [wstd_pkg::IDX_W-1:0] srv,
				logic [wstd_pkg::TIME_W-1:0] start_sec, logic [1:0] code);
			grant_t g;
			if (expected_grants.size() == 0) begin
				orphans++;
				$display("%0t: result with no task pending: server %0d start %0d status %0d",
					$realtime, srv, start_sec, code);
				return;
			end
			g = expected_grants.pop_front();
			if (code == wstd_pkg::STATUS_OK) begin
				grants_ok++;
				if (start_sec > latest_start)
					latest_start = start_sec;
			end else begin
				grants_empty++;
			end
			if (srv !== g.srv || start_sec !== g.start_sec || code !== g.code) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: server %0d/%0d start %0d/%0d status %0d/%0d %s",
						$realtime, srv, g.srv, start_sec, g.start_sec, code, g.code,
						"(actual/expected)");
			end
		endfunction

		function int pending();
			return expected_grants.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic                          operation = wstd_pkg::OP_LOAD;
	logic [wstd_pkg::IDX_W-1:0]    server_index = '0;
	logic [wstd_pkg::WEIGHT_W-1:0] server_weight = '0;
	logic [wstd_pkg::DUR_W-1:0]    task_duration = '0;
	logic                          done;
	logic [wstd_pkg::IDX_W-1:0]    assigned_server;
	logic [wstd_pkg::TIME_W-1:0]   start_time;
	logic [1:0]                    status;

	dispatch_board board;
	int cycles = 0;
	int words_sent = 0;
	int gap_max = 16;
	int drains = 0;

	weighted_server_task_dispatcher i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.server_index    (server_index),
		.server_weight   (server_weight),
		.task_duration   (task_duration),
		.done            (done),
		.assigned_server (assigned_server),
		.start_time      (start_time),
		.status          (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles,
				board.pending());
			$display("** weighted_server_task_dispatcher: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done && board != null)
			board.check_word(assigned_server, start_time, status);
	end

	// Present one word and hold it until the block takes it.
	task automatic send_word(input logic op, input logic [wstd_pkg::IDX_W-1:0] idx,
			input logic [wstd_pkg::WEIGHT_W-1:0] wgt,
			input logic [wstd_pkg::DUR_W-1:0] dur);
		int gap;
		gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		server_index <= idx;
		server_weight <= wgt;
		task_duration <= dur;
		do
			@(posedge clk);
		while (busy);
		board.note_word(op, idx, wgt, dur);
		words_sent++;
	endtask

	task automatic send_task(input logic [wstd_pkg::DUR_W-1:0] dur);
		send_word(wstd_pkg::OP_TASK, wstd_pkg::IDX_W'($urandom),
			wstd_pkg::WEIGHT_W'($urandom), dur);
	endtask

	task automatic send_load(input logic [wstd_pkg::IDX_W-1:0] idx,
			input logic [wstd_pkg::WEIGHT_W-1:0] wgt);
		send_word(wstd_pkg::OP_LOAD, idx, wgt, wstd_pkg::DUR_W'($urandom));
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
		drains++;
	endtask

	function automatic logic [wstd_pkg::WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return WEIGHT_MAX;
			2, 3: return wstd_pkg::WEIGHT_W'($urandom_range(0, 3));
			default: return wstd_pkg::WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic logic [wstd_pkg::DUR_W-1:0] pick_duration();
		case ($urandom_range(0, 15))
			0: return DUR_MAX;
			1: return wstd_pkg::DUR_W'($urandom_range(1, 1048575));
			2, 3: return wstd_pkg::DUR_W'($urandom_range(1, 2000));
			default: return wstd_pkg::DUR_W'($urandom_range(1, 30));
		endcase
	endfunction

	initial begin
		int loads;
		int tasks;
		int batch;
		board = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Tasks before any server is loaded.
		send_word(wstd_pkg::OP_TASK, '1, WEIGHT_MAX, DUR_MAX);
		send_word(wstd_pkg::OP_TASK, '0, '0, wstd_pkg::DUR_W'(1));
		// Extreme indexes and weights, and a weight tie between two servers.
		send_load(4'd0, WEIGHT_MAX);
		send_load(4'd15, '0);
		send_load(4'd5, '0);
		send_task(DUR_MAX);
		send_task(wstd_pkg::DUR_W'(1));
		send_task('0);
		send_task('0);
		send_task(DUR_MAX);
		send_task(DUR_MAX);
		// All servers busy far ahead, so time jumps to the earliest release.
		send_task(wstd_pkg::DUR_W'(3));
		send_task(wstd_pkg::DUR_W'(7));
		wait_for_results();
		send_load(4'd15, WEIGHT_MAX);
		send_task(DUR_MAX);
		send_task(DUR_MAX);
		send_task(DUR_MAX);
		send_task(wstd_pkg::DUR_W'(1));
		send_load(4'd10, wstd_pkg::WEIGHT_W'(20'h55555));
		send_load(4'd9, wstd_pkg::WEIGHT_W'(20'haaaaa));
		send_task(wstd_pkg::DUR_W'(20'h80000));
		send_task(wstd_pkg::DUR_W'(2));

		batch = 0;
		while (words_sent < ITEM_TARGET) begin
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
			loads = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 5);
			tasks = $urandom_range(1, 40);
			for (int i = 0; i < loads; i++)
				send_load(wstd_pkg::IDX_W'($urandom), pick_weight());
			for (int i = 0; i < tasks; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_load(wstd_pkg::IDX_W'($urandom), pick_weight());
				else
					send_task(pick_duration());
			end
			batch++;
			if (batch == 3 || $urandom_range(0, 9) == 0)
				wait_for_results();
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d words (%0d loads) over %0d batches with %0d full drains.",
			words_sent, board.loads_seen, batch, drains);
		$display("Checked %0d assigned tasks and %0d refused ones; latest start second %0d.",
			board.grants_ok, board.grants_empty, board.latest_start);
		if (board.mismatches + board.orphans + board.pending() == 0)
			$display("** weighted_server_task_dispatcher: PASSED **");
		else
			$display("** weighted_server_task_dispatcher: FAILED **");
		$finish;
	end

endmodule
